/* sv/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/lswc_pkg.sv */
// ---------------------------------------------------------------------------
// lswc_pkg
// Shared constants and types of the line segment window clipper.
// ---------------------------------------------------------------------------
package lswc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int CLIP_PASSES    = 4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Region code bits.
    localparam int CODE_LEFT   = 0;
    localparam int CODE_RIGHT  = 1;
    localparam int CODE_BOTTOM = 2;
    localparam int CODE_TOP    = 3;

    // Control from the sequencer to the serial divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status from the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage

/* sv/lswc_div.sv */
// ---------------------------------------------------------------------------
// lswc_div
// Bit-serial signed divider: one quotient bit per cycle, truncating toward
// zero, quotient 0 for a zero divisor.
// ---------------------------------------------------------------------------
module lswc_div #(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lswc_pkg::t_div_ctl         i_ctl,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [DEN_BITS-1:0] i_den,
    output lswc_pkg::t_div_sts         o_sts,
    output logic signed [NUM_BITS-1:0] o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num, n_num;
    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den, n_den;
    logic                r_neg, n_neg;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;

    always_comb begin
        n_num  = r_num;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        shifted = {r_rem[DEN_BITS-1:0], r_num[NUM_BITS-1]};
        diff    = shifted - {1'b0, r_den};
        if (i_ctl.start) begin
            n_num  = i_num[NUM_BITS-1] ? (~i_num + 1'b1) : i_num;
            n_den  = i_den[DEN_BITS-1] ? (~i_den + 1'b1) : i_den;
            n_neg  = i_num[NUM_BITS-1] ^ i_den[DEN_BITS-1];
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = CW'(NUM_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NUM_BITS-2:0], 1'b0};
            if (!diff[DEN_BITS]) begin
                n_rem = diff;
                n_q   = {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[NUM_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    // A zero divisor leaves every trial subtract positive; force zero then.
    assign o_quot = (r_den == '0) ? '0 :
                    (r_neg ? $signed(~r_q + 1'b1) : $signed(r_q));
endmodule

/* sv/line_segment_window_clipper.sv */
// ---------------------------------------------------------------------------
// line_segment_window_clipper
// Cohen-Sutherland clipping of one segment against a programmable window.
// ---------------------------------------------------------------------------
// A word is taken when i_start is high and o_busy is low. It yields one result
// word, shown for one cycle with o_done; the receiver cannot stall it. Each
// clip pass runs the multiply step, then the bit-serial divider, then a new
// region test; a trivial accept or reject goes straight from the test to the
// output, and a segment makes at most CLIP_PASSES (4) passes. The divider is
// the limiting unit. Window registers sit on an APB port at byte addresses 0,
// 4, 8 and 12.
module line_segment_window_clipper #(
    parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_done,
    output logic                         o_visible,
    output logic signed [COORD_BITS-1:0] o_clip_start_x,
    output logic signed [COORD_BITS-1:0] o_clip_start_y,
    output logic signed [COORD_BITS-1:0] o_clip_end_x,
    output logic signed [COORD_BITS-1:0] o_clip_end_y
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int PC = $clog2(lswc_pkg::CLIP_PASSES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic signed [COORD_BITS-1:0] r_wl, r_wb, r_wr, r_wt;
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [PW-1:0]         r_prod;
    logic signed [DW-1:0]         r_den;
    logic signed [COORD_BITS-1:0] r_base;
    logic                         r_horiz;
    logic [PC-1:0]                r_pass;
    logic                         r_done, r_vis;
    logic signed [COORD_BITS-1:0] r_ox0, r_oy0, r_ox1, r_oy1;

    logic [3:0] c0, c1, co;
    logic       wr_en;
    logic       use0;
    logic signed [DW-1:0]         ma, mb, md;
    logic signed [PW-1:0]         quot;
    logic signed [COORD_BITS-1:0] newc;
    lswc_pkg::t_div_ctl div_ctl;
    lswc_pkg::t_div_sts div_sts;

    function automatic logic [3:0] region(
        input logic signed [COORD_BITS-1:0] x, y, l, b, r, t
    );
        logic [3:0] c;
        c = '0;
        if (x < l) c[lswc_pkg::CODE_LEFT] = 1'b1;
        else if (x > r) c[lswc_pkg::CODE_RIGHT] = 1'b1;
        if (y < b) c[lswc_pkg::CODE_BOTTOM] = 1'b1;
        else if (y > t) c[lswc_pkg::CODE_TOP] = 1'b1;
        return c;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= '0;
            r_wb <= '0;
            r_wr <= '0;
            r_wt <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                lswc_pkg::REG_LEFT:   r_wl <= pwdata[COORD_BITS-1:0];
                lswc_pkg::REG_BOTTOM: r_wb <= pwdata[COORD_BITS-1:0];
                lswc_pkg::REG_RIGHT:  r_wr <= pwdata[COORD_BITS-1:0];
                lswc_pkg::REG_TOP:    r_wt <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lswc_pkg::REG_LEFT:   prdata = 32'($signed(r_wl));
            lswc_pkg::REG_BOTTOM: prdata = 32'($signed(r_wb));
            lswc_pkg::REG_RIGHT:  prdata = 32'($signed(r_wr));
            lswc_pkg::REG_TOP:    prdata = 32'($signed(r_wt));
            default:              prdata = '0;
        endcase
    end

    assign c0   = region(r_x0, r_y0, r_wl, r_wb, r_wr, r_wt);
    assign c1   = region(r_x1, r_y1, r_wl, r_wb, r_wr, r_wt);
    assign use0 = (c0 != '0);
    assign co   = use0 ? c0 : c1;

    // The crossing formula is taken from the start point; differences are
    // always formed from x0,y0 as the clipping math requires.
    always_comb begin
        if (co[lswc_pkg::CODE_TOP] || co[lswc_pkg::CODE_BOTTOM]) begin
            ma = DW'(r_x1) - DW'(r_x0);
            mb = (co[lswc_pkg::CODE_TOP] ? DW'(r_wt) : DW'(r_wb)) - DW'(r_y0);
            md = DW'(r_y1) - DW'(r_y0);
        end else begin
            ma = DW'(r_y1) - DW'(r_y0);
            mb = (co[lswc_pkg::CODE_RIGHT] ? DW'(r_wr) : DW'(r_wl)) - DW'(r_x0);
            md = DW'(r_x1) - DW'(r_x0);
        end
    end

    assign div_ctl.start = (r_state == S_MUL);

    lswc_div #(
        .NUM_BITS(PW),
        .DEN_BITS(DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (div_ctl),
        .i_num  (r_prod),
        .i_den  (r_den),
        .o_sts  (div_sts),
        .o_quot (quot)
    );

    assign newc = r_base + quot[COORD_BITS-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_TEST;
            S_TEST: begin
                if ((c0 == '0 && c1 == '0) || (c0 & c1) != '0 ||
                        r_pass == PC'(lswc_pkg::CLIP_PASSES))
                    n_state = S_OUT;
                else
                    n_state = S_MUL;
            end
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (div_sts.done) n_state = S_TEST;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_TEST) && (n_state == S_OUT);
            if (r_state == S_IDLE) r_pass <= '0;
            else if (r_state == S_MUL) r_pass <= r_pass + 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                r_x0 <= i_start_x;
                r_y0 <= i_start_y;
                r_x1 <= i_end_x;
                r_y1 <= i_end_y;
            end
            S_TEST: begin
                r_prod  <= ma * mb;
                r_den   <= md;
                r_horiz <= co[lswc_pkg::CODE_TOP] || co[lswc_pkg::CODE_BOTTOM];
                r_base  <= (co[lswc_pkg::CODE_TOP] || co[lswc_pkg::CODE_BOTTOM])
                           ? r_x0 : r_y0;
                r_vis   <= (c0 == '0) && (c1 == '0);
                r_ox0   <= r_x0;
                r_oy0   <= r_y0;
                r_ox1   <= r_x1;
                r_oy1   <= r_y1;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (c0 != '0) begin
                        r_x0 <= r_horiz ? newc : (co[lswc_pkg::CODE_RIGHT] ? r_wr : r_wl);
                        r_y0 <= r_horiz ? (co[lswc_pkg::CODE_TOP] ? r_wt : r_wb) : newc;
                    end else begin
                        r_x1 <= r_horiz ? newc : (co[lswc_pkg::CODE_RIGHT] ? r_wr : r_wl);
                        r_y1 <= r_horiz ? (co[lswc_pkg::CODE_TOP] ? r_wt : r_wb) : newc;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_busy         = (r_state != S_IDLE) || r_done;
    assign o_done         = r_done;
    assign o_visible      = r_vis;
    assign o_clip_start_x = r_vis ? r_ox0 : '0;
    assign o_clip_start_y = r_vis ? r_oy0 : '0;
    assign o_clip_end_x   = r_vis ? r_ox1 : '0;
    assign o_clip_end_y   = r_vis ? r_oy1 : '0;
endmodule

/* sv/lswc_checker.sv */
// ---------------------------------------------------------------------------
// lswc_checker
// Port-level checks of the clipper's command handshake and results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lswc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input logic pready
);
    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "busy not raised")
    `CHK_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done longer than a cycle")
    `CHK_IMPLY(a_done_busy, i_clk, i_rst_n, o_done, o_busy, "result while idle")
    `CHK_IMPLY(a_ready, i_clk, i_rst_n, 1'b1, pready, "pready low")
    `CHK_NEXT(a_idle_after, i_clk, i_rst_n, o_done, !o_busy, "not idle after result")
endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .pready   (pready)
);

/* test/tb_line_segment_window_clipper.sv */
// ---------------------------------------------------------------------------
// tb_line_segment_window_clipper
// Self-checking bench for the Cohen-Sutherland segment clipper.
// ---------------------------------------------------------------------------
// Segments are sent in bursts with random gaps. Each accepted word takes its
// expected result from the directed table or from a clipping predictor that
// shares the window settings written over APB. Every result word is compared
// with the oldest expected result. The directed table comes first, then random
// segments under several windows, normal, full range and inverted among them.
module tb_line_segment_window_clipper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = lswc_pkg::COORD_BITS_DEF;
    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord sx, sy, ex, ey;
    } t_segment;

    typedef struct packed {
        logic   visible;
        t_coord sx, sy, ex, ey;
    } t_clip;

    typedef struct {
        int       win;
        t_segment seg;
        bit       typed;
        t_clip    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_start;
    logic        o_busy;
    t_coord      i_start_x, i_start_y, i_end_x, i_end_y;
    logic        o_done, o_visible;
    t_coord      o_clip_start_x, o_clip_start_y, o_clip_end_x, o_clip_end_y;

    line_segment_window_clipper i_dut (.*);

    // Window shadow: left, bottom, right, top.
    longint win_reg [4];
    t_clip  clip_q [$];
    int     accepts;
    int     mismatches;
    bit     typed_pending;
    t_clip  typed_want;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint wrap_coord(longint v);
        t_coord t;
        t = v[CB-1:0];
        return longint'(t);
    endfunction

    function automatic int region_code(longint x, longint y);
        int c;
        c = 0;
        if (x < win_reg[lswc_pkg::REG_LEFT]) c |= 1 << lswc_pkg::CODE_LEFT;
        else if (x > win_reg[lswc_pkg::REG_RIGHT]) c |= 1 << lswc_pkg::CODE_RIGHT;
        if (y < win_reg[lswc_pkg::REG_BOTTOM]) c |= 1 << lswc_pkg::CODE_BOTTOM;
        else if (y > win_reg[lswc_pkg::REG_TOP]) c |= 1 << lswc_pkg::CODE_TOP;
        return c;
    endfunction

    // Differences are at most CB+1 bits, so the product fits a longint.
    function automatic longint crossing(longint base, longint a, longint b, longint c);
        if (c == 0) return wrap_coord(base);
        return wrap_coord(base + (a * b) / c);
    endfunction

    function automatic t_clip clip_segment(t_segment s);
        longint x0, y0, x1, y1, nx, ny;
        int     c0, c1, co;
        bit     acc;
        t_clip  r;
        x0 = longint'(s.sx); y0 = longint'(s.sy);
        x1 = longint'(s.ex); y1 = longint'(s.ey);
        c0 = region_code(x0, y0);
        c1 = region_code(x1, y1);
        acc = 1'b0;
        for (int pass = 0; pass <= lswc_pkg::CLIP_PASSES; pass++) begin
            if (c0 == 0 && c1 == 0) begin
                acc = 1'b1;
                break;
            end
            if ((c0 & c1) != 0 || pass == lswc_pkg::CLIP_PASSES) break;
            co = (c0 != 0) ? c0 : c1;
            if (co & (1 << lswc_pkg::CODE_TOP)) begin
                nx = crossing(x0, x1 - x0, win_reg[lswc_pkg::REG_TOP] - y0, y1 - y0);
                ny = win_reg[lswc_pkg::REG_TOP];
            end else if (co & (1 << lswc_pkg::CODE_BOTTOM)) begin
                nx = crossing(x0, x1 - x0, win_reg[lswc_pkg::REG_BOTTOM] - y0, y1 - y0);
                ny = win_reg[lswc_pkg::REG_BOTTOM];
            end else if (co & (1 << lswc_pkg::CODE_RIGHT)) begin
                ny = crossing(y0, y1 - y0, win_reg[lswc_pkg::REG_RIGHT] - x0, x1 - x0);
                nx = win_reg[lswc_pkg::REG_RIGHT];
            end else begin
                ny = crossing(y0, y1 - y0, win_reg[lswc_pkg::REG_LEFT] - x0, x1 - x0);
                nx = win_reg[lswc_pkg::REG_LEFT];
            end
            if (c0 != 0) begin
                x0 = nx; y0 = ny; c0 = region_code(x0, y0);
            end else begin
                x1 = nx; y1 = ny; c1 = region_code(x1, y1);
            end
        end
        r.visible = acc;
        r.sx = acc ? t_coord'(x0) : '0;
        r.sy = acc ? t_coord'(y0) : '0;
        r.ex = acc ? t_coord'(x1) : '0;
        r.ey = acc ? t_coord'(y1) : '0;
        return r;
    endfunction

    // Accepted segments and result words are both taken at the rising edge.
    always @(posedge i_clk) begin
        t_segment s;
        t_clip    got, want;
        if (i_rst_n && i_start && !o_busy) begin
            s.sx = i_start_x; s.sy = i_start_y; s.ex = i_end_x; s.ey = i_end_y;
            clip_q.push_back(typed_pending ? typed_want : clip_segment(s));
            accepts++;
        end
        if (i_rst_n && o_done) begin
            got.visible = o_visible;
            got.sx = o_clip_start_x; got.sy = o_clip_start_y;
            got.ex = o_clip_end_x;   got.ey = o_clip_end_y;
            if (clip_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                want = clip_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want %0d (%0d,%0d)-(%0d,%0d)",
                                  " got %0d (%0d,%0d)-(%0d,%0d)"},
                                 want.visible, want.sx, want.sy, want.ex, want.ey,
                                 got.visible, got.sx, got.sy, got.ex, got.ey);
                end
            end
        end
    end

    task automatic write_window(logic [1:0] idx, longint value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        win_reg[idx] = wrap_coord(value);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_start = 1'b0;
        while (clip_q.size() != 0 && n < 100000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_window(longint l, longint b, longint r, longint t);
        drain();
        write_window(lswc_pkg::REG_LEFT, l);
        write_window(lswc_pkg::REG_BOTTOM, b);
        write_window(lswc_pkg::REG_RIGHT, r);
        write_window(lswc_pkg::REG_TOP, t);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_segment(t_segment s);
        int n;
        n = accepts;
        i_start = 1'b1;
        i_start_x = s.sx; i_start_y = s.sy; i_end_x = s.ex; i_end_y = s.ey;
        do @(negedge i_clk); while (accepts == n);
    endtask

    function automatic t_coord pick_coord(longint lo, longint hi);
        longint v;
        if ($urandom_range(3) == 0) return t_coord'($urandom);
        if (lo > hi) begin
            v = lo; lo = hi; hi = v;
        end
        lo = (lo - 300 < -32768) ? -32768 : lo - 300;
        hi = (hi + 300 > 32767) ? 32767 : hi + 300;
        return t_coord'(lo + longint'($urandom_range(32'(hi - lo))));
    endfunction

    function automatic t_segment seg(longint a, longint b, longint c, longint d);
        t_segment s;
        s.sx = t_coord'(a); s.sy = t_coord'(b); s.ex = t_coord'(c); s.ey = t_coord'(d);
        return s;
    endfunction

    function automatic t_clip same(logic v, t_segment s);
        t_clip r;
        r.visible = v; r.sx = s.sx; r.sy = s.sy; r.ex = s.ex; r.ey = s.ey;
        return r;
    endfunction

    t_row   dir_rows [$];
    longint windows [4][4] = '{
        '{0, 0, 0, 0},
        '{-32768, -32768, 32767, 32767},
        '{-100, -50, 100, 50},
        '{50, 40, -50, -40}
    };

    initial begin
        t_row     rw;
        t_segment s;
        t_clip    zero;
        int       cur_win, burst;
        longint   l, b, r, t;

        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_start = 1'b0; i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        typed_pending = 1'b0; accepts = 0; mismatches = 0;
        zero = same(1'b0, seg(0, 0, 0, 0));
        foreach (win_reg[k]) win_reg[k] = 0;

        // Window after reset is the single point at the origin.
        dir_rows.push_back('{0, seg(0, 0, 0, 0), 1'b1, same(1'b1, seg(0, 0, 0, 0))});
        dir_rows.push_back('{0, seg(1, 1, 2, 2), 1'b1, zero});
        // Full-range window: every segment is visible and unchanged.
        s = seg(-32768, -32768, 32767, 32767);
        dir_rows.push_back('{1, s, 1'b1, same(1'b1, s)});
        s = seg(32767, -32768, -32768, 32767);
        dir_rows.push_back('{1, s, 1'b1, same(1'b1, s)});
        s = seg(-1, 0, 0, -1);
        dir_rows.push_back('{1, s, 1'b1, same(1'b1, s)});
        // Small window: trivial cases, each edge, corners and extremes.
        dir_rows.push_back('{2, seg(-10, 5, 20, -7), 1'b1, same(1'b1, seg(-10, 5, 20, -7))});
        dir_rows.push_back('{2, seg(-200, 0, -150, 10), 1'b1, zero});
        dir_rows.push_back('{2, seg(150, 0, 300, 10), 1'b1, zero});
        dir_rows.push_back('{2, seg(0, -60, 10, -90), 1'b1, zero});
        dir_rows.push_back('{2, seg(0, 60, 10, 90), 1'b1, zero});
        dir_rows.push_back('{2, seg(-300, 7, 300, 9), 1'b0, zero});
        dir_rows.push_back('{2, seg(3, -300, 5, 300), 1'b0, zero});
        dir_rows.push_back('{2, seg(-300, -300, 300, 300), 1'b0, zero});
        dir_rows.push_back('{2, seg(-300, 300, 300, -300), 1'b0, zero});
        dir_rows.push_back('{2, seg(-32768, -32768, 32767, 32767), 1'b0, zero});
        dir_rows.push_back('{2, seg(32767, 0, -32768, 1), 1'b0, zero});
        dir_rows.push_back('{2, seg(-150, 0, 0, 100), 1'b0, zero});
        dir_rows.push_back('{2, seg(0, 0, 500, 1), 1'b0, zero});
        dir_rows.push_back('{2, seg(500, 500, 500, 500), 1'b1, zero});
        // Inverted window: codes never clear, so a shared code or the pass limit rejects.
        dir_rows.push_back('{3, seg(0, 0, 1, 1), 1'b0, zero});
        dir_rows.push_back('{3, seg(-32768, 32767, 32767, -32768), 1'b0, zero});
        dir_rows.push_back('{3, seg(60, 0, -60, 5), 1'b0, zero});

        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        cur_win = 0;
        foreach (dir_rows[k]) begin
            rw = dir_rows[k];
            if (rw.win != cur_win) begin
                cur_win = rw.win;
                set_window(windows[cur_win][0], windows[cur_win][1],
                           windows[cur_win][2], windows[cur_win][3]);
            end
            typed_pending = rw.typed;
            typed_want = rw.want;
            send_segment(rw.seg);
            typed_pending = 1'b0;
            if ($urandom_range(1)) begin
                i_start = 1'b0;
                repeat ($urandom_range(4)) @(negedge i_clk);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin l = -32768; b = -32768; r = 32767; t = 32767; end
                3: begin l = 7; b = 7; r = 7; t = 7; end
                5: begin
                    l = longint'($urandom_range(2000));
                    r = -longint'($urandom_range(2000));
                    b = longint'($urandom_range(2000));
                    t = -longint'($urandom_range(2000));
                end
                default: begin
                    l = longint'(t_coord'($urandom)); r = longint'(t_coord'($urandom));
                    b = longint'(t_coord'($urandom)); t = longint'(t_coord'($urandom));
                    if (l > r) begin l ^= r; r ^= l; l ^= r; end
                    if (b > t) begin b ^= t; t ^= b; b ^= t; end
                end
            endcase
            set_window(l, b, r, t);
            burst = 0;
            for (int k = 0; k < 80; k++) begin
                send_segment(seg(pick_coord(l, r), pick_coord(b, t),
                                 pick_coord(l, r), pick_coord(b, t)));
                if (burst == 0) begin
                    burst = int'($urandom_range(12, 1));
                    if (ph != 2) begin
                        i_start = 1'b0;
                        repeat ($urandom_range(30)) @(negedge i_clk);
                    end
                end
                burst--;
                // Hold the sender off until the clipper has fully drained.
                if (k == 40) drain();
            end
        end

        drain();
        if (mismatches == 0 && clip_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
